>>> rtl/core/lrm_pkg.sv
// Shared types and constants for the loss report monitor.
`default_nettype none

package lrm_pkg;

   // Event codes carried on req_action.
   localparam logic [1:0] ACT_LOST = 2'd0;
   localparam logic [1:0] ACT_RECV = 2'd1;
   localparam logic [1:0] ACT_PEER = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RECV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [7:0]  MIN_RECV_RESET = 8'd30;
   localparam logic [15:0] INTERVAL_RESET = 16'd950;
   localparam logic [7:0]  EVENT_MAX      = 8'hFF;

   // Fraction divider: one quotient bit per cycle.
   localparam int unsigned FRAC_W    = 17;
   localparam int unsigned DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd16;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/loss_report_monitor.sv
// Flow: an item is captured in IDLE, evaluated in EXEC and loaded into the output
// register in DELIVER for lost, received and rejected or lossless peer events; a peer
// report with loss also passes through DIV, where the bit-serial 17-step fraction
// divider runs. DELIVER waits while the output register is full and not being drained.
// Reset: synchronous; clears the totals, event count and both timestamps and
// loads the registers with 30 receive events and 950 ms.
`default_nettype none

module loss_report_monitor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [lrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lrm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [31:0]                   req_byte_count,
   input  wire logic [31:0]                   req_peer_lost,
   input  wire logic [31:0]                   req_peer_recv,
   input  wire logic [31:0]                   req_now_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_report_valid,
   output logic [31:0]                        rsp_report_lost,
   output logic [31:0]                        rsp_report_recv,
   output logic                               rsp_fraction_valid,
   output logic [lrm_pkg::FRAC_W-1:0]         rsp_loss_fraction,
   output logic                               rsp_update_rejected
);
   import lrm_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_action          (req_action),
      .req_byte_count      (req_byte_count),
      .req_peer_lost       (req_peer_lost),
      .req_peer_recv       (req_peer_recv),
      .req_now_ms          (req_now_ms),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_report_lost     (rsp_report_lost),
      .rsp_report_recv     (rsp_report_recv),
      .rsp_fraction_valid  (rsp_fraction_valid),
      .rsp_loss_fraction   (rsp_loss_fraction),
      .rsp_update_rejected (rsp_update_rejected)
   );

   // Only one item is in flight, so a transfer closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item was in flight");

   // A report is sent only when the lost total is nonzero.
   a_report_has_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_valid) |-> (rsp_report_lost != 32'd0))
      else $error("report sent with zero lost total");

   // A result carries at most one kind of outcome.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_report_valid, rsp_fraction_valid,
                                 rsp_update_rejected}) <= 1))
      else $error("result carries more than one outcome");

   // The fraction never exceeds one.
   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_loss_fraction[FRAC_W-1] && rsp_loss_fraction[FRAC_W-2:0] != '0))
      else $error("loss fraction above one");

endmodule

`default_nettype wire

>>> rtl/core/lrm_ctrl.sv
// Controller state machine for the loss report monitor.
`default_nettype none

module lrm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire lrm_pkg::status_type status,
   output lrm_pkg::cmd_type        cmd
);
   import lrm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = req_valid && (state_ff == ST_IDLE);
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.load_out = (state_ff == ST_DELIVER) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= status.need_div ? ST_DIV : ST_DELIVER;
            end
            ST_DIV: begin
               if (status.div_last) state_ff <= ST_DELIVER;
            end
            ST_DELIVER: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lrm_dp.sv
// Datapath of the loss report monitor: accumulators, timers, divider, output register.
`default_nettype none

module lrm_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lrm_pkg::cmd_type              cmd,
   output lrm_pkg::status_type                status,
   input  wire logic                          csr_we,
   input  wire logic [lrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lrm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [1:0]                    req_action,
   input  wire logic [31:0]                   req_byte_count,
   input  wire logic [31:0]                   req_peer_lost,
   input  wire logic [31:0]                   req_peer_recv,
   input  wire logic [31:0]                   req_now_ms,
   output logic                               rsp_report_valid,
   output logic [31:0]                        rsp_report_lost,
   output logic [31:0]                        rsp_report_recv,
   output logic                               rsp_fraction_valid,
   output logic [lrm_pkg::FRAC_W-1:0]         rsp_loss_fraction,
   output logic                               rsp_update_rejected
);
   import lrm_pkg::*;

   // Configuration.
   logic [7:0]  min_recv_ff;
   logic [15:0] interval_ff;

   // Captured event.
   logic [1:0]  act_ff;
   logic [31:0] count_ff, plost_ff, precv_ff, now_ff;

   // Monitor state.
   logic [31:0] lost_total_ff, lost_total_in;
   logic [31:0] recv_total_ff, recv_total_in;
   logic [7:0]  event_cnt_ff, event_cnt_in;
   logic [31:0] last_sent_ff, last_sent_in;
   logic [31:0] last_peer_ff, last_peer_in;

   // Result staging.
   logic        stg_report_valid_ff, stg_frac_valid_ff, stg_reject_ff;
   logic [31:0] stg_lost_ff, stg_recv_ff;

   // Divider.
   logic [32:0]          rem_ff, rem_in;
   logic [32:0]          den_ff;
   logic [FRAC_W-1:0]    quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [33:0]          trial;
   logic [34:0]          diff;
   logic                 quo_bit;

   logic [32:0] lost_sum, recv_sum;
   logic [31:0] lost_sat, recv_sat, new_lost, new_recv;
   logic [31:0] elapsed, earliest;
   logic [7:0]  new_cnt;
   logic        is_lost, is_recv, is_peer, due, reject, peer_ok, need_div;

   always_comb begin
      is_lost  = (act_ff == ACT_LOST) && (count_ff != 32'd0);
      is_recv  = (act_ff == ACT_RECV) && (count_ff != 32'd0);
      is_peer  = (act_ff == ACT_PEER);
      lost_sum = {1'b0, lost_total_ff} + {1'b0, count_ff};
      recv_sum = {1'b0, recv_total_ff} + {1'b0, count_ff};
      lost_sat = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
      recv_sat = recv_sum[32] ? 32'hFFFF_FFFF : recv_sum[31:0];
      new_lost = is_lost ? lost_sat : lost_total_ff;
      new_recv = is_recv ? recv_sat : recv_total_ff;
      new_cnt  = (is_recv && event_cnt_ff != EVENT_MAX) ? event_cnt_ff + 8'd1 : event_cnt_ff;
      elapsed  = now_ff - last_sent_ff;
      due      = (is_lost || is_recv) && (new_cnt > min_recv_ff)
                 && (elapsed > {16'd0, interval_ff});
      earliest = last_peer_ff + {16'd0, interval_ff};
      reject   = is_peer && (earliest > now_ff);
      peer_ok  = is_peer && !reject;
      need_div = peer_ok && (plost_ff != 32'd0);

      lost_total_in = lost_total_ff;
      recv_total_in = recv_total_ff;
      event_cnt_in  = event_cnt_ff;
      last_sent_in  = last_sent_ff;
      last_peer_in  = last_peer_ff;
      if (cmd.exec) begin
         lost_total_in = due ? 32'd0 : new_lost;
         recv_total_in = due ? 32'd0 : new_recv;
         event_cnt_in  = due ? 8'd0 : new_cnt;
         last_sent_in  = due ? now_ff : last_sent_ff;
         last_peer_in  = peer_ok ? now_ff : last_peer_ff;
      end
   end

   // The first step compares the unshifted remainder; it sets the top
   // quotient bit only when the peer reported no received bytes.
   always_comb begin
      trial   = (div_cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      quo_bit = !diff[34];
      rem_in  = quo_bit ? diff[32:0] : trial[32:0];
   end

   assign status.need_div = need_div;
   assign status.div_last = (div_cnt_ff == DIV_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_recv_ff   <= MIN_RECV_RESET;
         interval_ff   <= INTERVAL_RESET;
         lost_total_ff <= '0;
         recv_total_ff <= '0;
         event_cnt_ff  <= '0;
         last_sent_ff  <= '0;
         last_peer_ff  <= '0;
      end else begin
         if (csr_we && csr_index == CSR_MIN_RECV) min_recv_ff <= csr_wdata[7:0];
         if (csr_we && csr_index == CSR_INTERVAL) interval_ff <= csr_wdata[15:0];
         lost_total_ff <= lost_total_in;
         recv_total_ff <= recv_total_in;
         event_cnt_ff  <= event_cnt_in;
         last_sent_ff  <= last_sent_in;
         last_peer_ff  <= last_peer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         count_ff <= req_byte_count;
         plost_ff <= req_peer_lost;
         precv_ff <= req_peer_recv;
         now_ff   <= req_now_ms;
      end
      if (cmd.exec) begin
         stg_report_valid_ff <= due && (new_lost != 32'd0);
         stg_lost_ff         <= (due && new_lost != 32'd0) ? new_lost : 32'd0;
         stg_recv_ff         <= (due && new_lost != 32'd0) ? new_recv : 32'd0;
         stg_frac_valid_ff   <= need_div;
         stg_reject_ff       <= reject;
         rem_ff              <= {1'b0, plost_ff};
         den_ff              <= {1'b0, plost_ff} + {1'b0, precv_ff};
         quo_ff              <= '0;
         div_cnt_ff          <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         quo_ff     <= {quo_ff[FRAC_W-2:0], quo_bit};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.load_out) begin
         rsp_report_valid    <= stg_report_valid_ff;
         rsp_report_lost     <= stg_lost_ff;
         rsp_report_recv     <= stg_recv_ff;
         rsp_fraction_valid  <= stg_frac_valid_ff;
         rsp_loss_fraction   <= stg_frac_valid_ff ? quo_ff : '0;
         rsp_update_rejected <= stg_reject_ff;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the loss report monitor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lrm_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [1:0]           ACT_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int          DRAIN_CYCLES = 25;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] byte_count;
      logic [31:0] peer_lost;
      logic [31:0] peer_recv;
      logic [31:0] now_ms;
   } event_type;

   typedef struct packed {
      logic              report_valid;
      logic [31:0]       report_lost;
      logic [31:0]       report_recv;
      logic              fraction_valid;
      logic [FRAC_W-1:0] loss_fraction;
      logic              update_rejected;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action = '0;
   logic [31:0]           req_byte_count = '0;
   logic [31:0]           req_peer_lost = '0;
   logic [31:0]           req_peer_recv = '0;
   logic [31:0]           req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_report_valid;
   logic [31:0]           rsp_report_lost;
   logic [31:0]           rsp_report_recv;
   logic                  rsp_fraction_valid;
   logic [FRAC_W-1:0]     rsp_loss_fraction;
   logic                  rsp_update_rejected;

   loss_report_monitor u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_byte_count      (req_byte_count),
      .req_peer_lost       (req_peer_lost),
      .req_peer_recv       (req_peer_recv),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_report_lost     (rsp_report_lost),
      .rsp_report_recv     (rsp_report_recv),
      .rsp_fraction_valid  (rsp_fraction_valid),
      .rsp_loss_fraction   (rsp_loss_fraction),
      .rsp_update_rejected (rsp_update_rejected)
   );

   // Mirror of the block's registers and state.
   logic [7:0]  cfg_min_recv = MIN_RECV_RESET;
   logic [15:0] cfg_interval_ms = INTERVAL_RESET;
   logic [31:0] lost_sum = '0;
   logic [31:0] recv_sum = '0;
   logic [7:0]  recv_events = '0;
   logic [31:0] last_report_ms = '0;
   logic [31:0] last_peer_ms = '0;

   outcome_type pending_results[$];
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic [31:0] now_cursor = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // After a lost or received event: once enough receive events have been seen and the
   // interval since the last report has run out, clear the totals; report any loss.
   function automatic outcome_type settle_report(input logic [31:0] now);
      outcome_type res;
      logic [31:0] elapsed;
      res = '0;
      elapsed = now - last_report_ms;
      if (recv_events > cfg_min_recv && elapsed > {16'd0, cfg_interval_ms}) begin
         recv_events = '0;
         if (lost_sum != 0) begin
            res.report_valid = 1'b1;
            res.report_lost = lost_sum;
            res.report_recv = recv_sum;
         end
         last_report_ms = now;
         lost_sum = '0;
         recv_sum = '0;
      end
      return res;
   endfunction

   function automatic outcome_type monitor_outcome(input event_type ev);
      outcome_type res;
      logic [31:0] earliest;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quot;
      res = '0;
      case (ev.action)
         ACT_LOST: begin
            if (ev.byte_count != 0) begin
               lost_sum = sat_add(lost_sum, ev.byte_count);
               res = settle_report(ev.now_ms);
            end
         end
         ACT_RECV: begin
            if (ev.byte_count != 0) begin
               if (recv_events != EVENT_MAX) recv_events++;
               recv_sum = sat_add(recv_sum, ev.byte_count);
               res = settle_report(ev.now_ms);
            end
         end
         ACT_PEER: begin
            // The earliest acceptable time wraps at 32 bits; the compare does not.
            earliest = last_peer_ms + {16'd0, cfg_interval_ms};
            if (earliest > ev.now_ms) begin
               res.update_rejected = 1'b1;
            end else begin
               last_peer_ms = ev.now_ms;
               if (ev.peer_lost != 0) begin
                  num = {32'd0, ev.peer_lost} << 16;
                  den = {32'd0, ev.peer_lost} + {32'd0, ev.peer_recv};
                  quot = num / den;
                  res.fraction_valid = 1'b1;
                  res.loss_fraction = quot[FRAC_W-1:0];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic string show_outcome(input outcome_type r);
      return $sformatf("report %0b lost %h recv %h fraction %0b/%h rejected %0b",
                       r.report_valid, r.report_lost, r.report_recv,
                       r.fraction_valid, r.loss_fraction, r.update_rejected);
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.report_valid = rsp_report_valid;
         got.report_lost = rsp_report_lost;
         got.report_recv = rsp_report_recv;
         got.fraction_valid = rsp_fraction_valid;
         got.loss_fraction = rsp_loss_fraction;
         got.update_rejected = rsp_update_rejected;
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("cycle %0d: unexpected result: %s", cycle_count, show_outcome(got));
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("cycle %0d: result mismatch", cycle_count);
                  $display("   expected %s", show_outcome(want));
                  $display("   actual   %s", show_outcome(got));
               end
               mismatch_count++;
            end
         end
      end
   end

   // The expected result is queued before the transfer; results come back in order.
   task automatic send_event(input event_type ev);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      pending_results.push_back(monitor_outcome(ev));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= ev.action;
      req_byte_count <= ev.byte_count;
      req_peer_lost <= ev.peer_lost;
      req_peer_recv <= ev.peer_recv;
      req_now_ms <= ev.now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MIN_RECV) cfg_min_recv = value[7:0];
      else if (idx == CSR_INTERVAL) cfg_interval_ms = value;
   endtask

   task automatic configure(input logic [7:0] min_recv, input logic [15:0] interval_ms);
      write_csr(CSR_MIN_RECV, {8'd0, min_recv});
      write_csr(CSR_INTERVAL, interval_ms);
   endtask

   function automatic event_type make_event(input logic [1:0] action,
                                            input logic [31:0] count,
                                            input logic [31:0] plost,
                                            input logic [31:0] precv,
                                            input logic [31:0] now);
      event_type ev;
      ev.action = action;
      ev.byte_count = count;
      ev.peer_lost = plost;
      ev.peer_recv = precv;
      ev.now_ms = now;
      return ev;
   endfunction

   function automatic event_type random_event(input int recv_pct, input int unsigned step_max,
                                              input int jump_pct);
      event_type ev;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 3) ev.action = ACT_UNUSED;
      else if (pick < 3 + recv_pct) ev.action = ACT_RECV;
      else ev.action = $urandom_range(1) ? ACT_LOST : ACT_PEER;

      // Mostly small time steps, some past the longest interval, rarely anywhere.
      pick = $urandom_range(99);
      if (pick == 99) now_cursor += $urandom;
      else if (pick < jump_pct) now_cursor += $urandom_range(0, 131072);
      else now_cursor += $urandom_range(0, step_max);
      ev.now_ms = now_cursor;

      pick = $urandom_range(99);
      if (pick < 5) ev.byte_count = '0;
      else if (pick < 10) ev.byte_count = $urandom | 32'h8000_0000;
      else if (pick < 15) ev.byte_count = $urandom;
      else ev.byte_count = $urandom_range(1, 1500);

      pick = $urandom_range(99);
      if (pick < 25) ev.peer_lost = '0;
      else if (pick < 35) ev.peer_lost = $urandom;
      else ev.peer_lost = $urandom_range(1, 5000);

      pick = $urandom_range(99);
      if (pick < 10) ev.peer_recv = '0;
      else if (pick < 25) ev.peer_recv = $urandom;
      else ev.peer_recv = $urandom_range(0, 100000);
      return ev;
   endfunction

   task automatic run_traffic(input int n_items, input int recv_pct,
                              input int unsigned step_max, input int jump_pct);
      repeat (n_items) send_event(random_event(recv_pct, step_max, jump_pct));
   endtask

   // Reset settings: empty events, the unused action, peer timing and saturation.
   task automatic test_reset_settings();
      drain_results();
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_event(make_event(ACT_LOST, 32'd0, 32'd9, 32'd9, 32'd5));
      send_event(make_event(ACT_RECV, 32'd0, 32'd9, 32'd9, 32'd6));
      send_event(make_event(ACT_UNUSED, '1, '1, '1, '1));
      send_event(make_event(ACT_PEER, 32'd0, 32'd10, 32'd20, 32'd100));
      send_event(make_event(ACT_PEER, 32'd0, 32'd0, 32'd77, 32'd950));
      send_event(make_event(ACT_PEER, 32'd0, 32'd5, 32'd5, 32'd1899));
      send_event(make_event(ACT_PEER, 32'd0, '1, 32'd0, 32'd1900));
      send_event(make_event(ACT_PEER, 32'd0, 32'd1, '1, 32'd2850));
      send_event(make_event(ACT_PEER, 32'd0, 32'd3, 32'd1, 32'd3800));
      send_event(make_event(ACT_LOST, '1, 32'd0, 32'd0, 32'd10));
      send_event(make_event(ACT_LOST, 32'd7, 32'd0, 32'd0, 32'd11));
      send_event(make_event(ACT_RECV, '1, 32'd0, 32'd0, 32'd20));
      send_event(make_event(ACT_RECV, 32'd3, 32'd0, 32'd0, 32'd21));
   endtask

   // Zero threshold and interval: the elapsed time must still be strictly positive,
   // and it is taken modulo 2^32.
   task automatic test_report_timing();
      drain_results();
      configure(8'd0, 16'd0);
      send_event(make_event(ACT_RECV, 32'd1, 32'd0, 32'd0, 32'd0));
      send_event(make_event(ACT_RECV, 32'd1, 32'd0, 32'd0, 32'd1));
      send_event(make_event(ACT_LOST, 32'd5, 32'd0, 32'd0, 32'd2));
      send_event(make_event(ACT_RECV, 32'd9, 32'd0, 32'd0, 32'hFFFF_FFFF));
      send_event(make_event(ACT_RECV, 32'd4, 32'd0, 32'd0, 32'd3));
      send_event(make_event(ACT_PEER, 32'd0, 32'd1, 32'd1, 32'd3799));
   endtask

   // Largest interval and a threshold of 254: the earliest peer time wraps past zero.
   task automatic test_interval_wrap();
      drain_results();
      configure(8'd254, 16'hFFFF);
      send_event(make_event(ACT_PEER, 32'd0, 32'd2, 32'd2, 32'hFFFF_FFF0));
      send_event(make_event(ACT_PEER, 32'd0, 32'd1, 32'd0, 32'd5));
      send_event(make_event(ACT_PEER, 32'd0, 32'd1, 32'd0, 32'd65519));
      send_event(make_event(ACT_LOST, 32'd1, 32'd0, 32'd0, 32'd0));
   endtask

   task automatic test_steady_traffic();
      drain_results();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      configure(8'd3, 16'd40);
      now_cursor = $urandom;
      run_traffic(250, 50, 30, 2);
   endtask

   task automatic test_sparse_sender();
      drain_results();
      send_idle_pct = 87;
      rsp_stall_pct = 0;
      configure(8'd0, 16'd0);
      now_cursor = $urandom;
      run_traffic(200, 50, 5, 2);
   endtask

   // Receive-heavy with a threshold of 254 so the event count reaches saturation.
   task automatic test_slow_receiver();
      drain_results();
      send_idle_pct = 0;
      rsp_stall_pct = 87;
      configure(8'd254, 16'hFFFF);
      now_cursor = $urandom;
      run_traffic(350, 85, 100, 1);
   endtask

   task automatic test_mixed_idle();
      drain_results();
      send_idle_pct = 33;
      rsp_stall_pct = 33;
      configure(8'($urandom_range(0, 12)), 16'($urandom_range(0, 3000)));
      now_cursor = 32'hFFFF_0000 + $urandom_range(0, 65535);
      run_traffic(250, 50, 400, 3);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_report_timing();
      test_interval_wrap();
      test_steady_traffic();
      test_sparse_sender();
      test_slow_receiver();
      test_mixed_idle();
      drain_results();
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
